FILE: hdl/assert_macros.svh
// assertion helpers used by bqeq_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/bqeq_pkg.sv
`timescale 1ns / 1ps
package bqeq_pkg;

    localparam int BANDS    = 8;
    localparam int CHANNELS = 2;
    localparam int TAPS     = 5;

    localparam int SMP_W   = 28;
    localparam int COEF_W  = 32;
    localparam int GAIN_W  = 24;
    localparam int EN_W    = 8;
    localparam int BAND_W  = 3;
    localparam int CH_W    = 1;
    localparam int TAP_W   = 3;
    localparam int PROD_W  = COEF_W + SMP_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CLP_W   = ACC_W - 20;
    localparam int CFG_IW  = 4;
    localparam int CFG_DW  = 24;

    localparam int C_DEPTH = BANDS * TAPS;
    localparam int C_AW    = $clog2(C_DEPTH);
    localparam int H_DEPTH = BANDS * CHANNELS;
    localparam int H_AW    = $clog2(H_DEPTH);
    localparam int HROW_W  = 4 * SMP_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1048576);

    localparam logic signed [ACC_W-1:0] RND_BAND = ACC_W'(2**29);
    localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(2**19);
    localparam logic signed [CLP_W-1:0] CLP_MAX  = CLP_W'(134217727);
    localparam logic signed [CLP_W-1:0] CLP_MIN  = -CLP_W'(134217728);

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_COEFF  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    localparam logic [TAP_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [TAP_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [TAP_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [TAP_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [TAP_W-1:0] SLOT_A2 = 3'd4;

    localparam logic [CFG_IW-1:0] REG_BAND_ENABLE = 4'd0;
    localparam logic [CFG_IW-1:0] REG_OUTPUT_GAIN = 4'd1;

    typedef struct packed {
        logic [1:0]               action;
        logic [CH_W-1:0]          channel;
        logic signed [SMP_W-1:0]  sample_in;
        logic [BAND_W-1:0]        coeff_band;
        logic [TAP_W-1:0]         coeff_slot;
        logic signed [COEF_W-1:0] coeff_value;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic [CH_W-1:0]         channel_out;
        logic                    saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] x1;
        logic signed [SMP_W-1:0] x2;
        logic signed [SMP_W-1:0] y1;
        logic signed [SMP_W-1:0] y2;
    } t_hist_row;

    typedef struct packed {
        logic mul_en;
        logic sub;
        logic acc_clr;
    } t_mac_ctl;

    typedef struct packed {
        logic                    sat;
        logic signed [SMP_W-1:0] val;
    } t_rnd;

    function automatic logic [C_AW-1:0] coef_addr(input logic [BAND_W-1:0] band,
                                                   input logic [TAP_W-1:0] slot);
        return C_AW'(C_AW'(band) * C_AW'(TAPS) + C_AW'(slot));
    endfunction

    function automatic logic [H_AW-1:0] hist_addr(input logic [BAND_W-1:0] band,
                                                   input logic [CH_W-1:0] ch);
        return H_AW'(H_AW'(band) * H_AW'(CHANNELS) + H_AW'(ch));
    endfunction

    function automatic t_rnd clamp_smp(input logic signed [CLP_W-1:0] v);
        t_rnd r;
        r.sat = 1'b1;
        if (v > CLP_MAX) begin
            r.val = CLP_MAX[SMP_W-1:0];
        end else if (v < CLP_MIN) begin
            r.val = CLP_MIN[SMP_W-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = v[SMP_W-1:0];
        end
        return r;
    endfunction

    function automatic t_rnd round_band(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        logic signed [31:0]      q;
        s = acc + RND_BAND;
        q = $signed(s[ACC_W-1:30]);
        return clamp_smp(CLP_W'(q));
    endfunction

    function automatic t_rnd round_gain(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        s = acc + RND_GAIN;
        return clamp_smp($signed(s[ACC_W-1:20]));
    endfunction

endpackage

FILE: hdl/bqeq_ram.sv
`timescale 1ns / 1ps
module bqeq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 40,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bqeq_mac.sv
`timescale 1ns / 1ps
module bqeq_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bqeq_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [bqeq_pkg::COEF_W-1:0]    i_a,
    input  logic signed [bqeq_pkg::SMP_W-1:0]     i_b,
    output logic signed [bqeq_pkg::ACC_W-1:0]     o_acc
);
    import bqeq_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic                     r_pvalid;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        n_prod = PROD_W'(i_a) * PROD_W'(i_b);
        n_acc  = r_acc;
        if (i_ctl.acc_clr) begin
            n_acc = '0;
        end else if (r_pvalid) begin
            if (r_sub) begin
                n_acc = r_acc - ACC_W'(r_prod);
            end else begin
                n_acc = r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_pvalid <= i_ctl.mul_en;
            r_acc    <= n_acc;
            if (i_ctl.mul_en) begin
                r_prod <= n_prod;
                r_sub  <= i_ctl.sub;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hdl/biquad_cascade_equaliser.sv
// Eight-band biquad equaliser for two channels, samples Q5.23, coefficients Q2.30,
// output gain Q4.20. A sample word keeps the block busy while it passes through the
// bands; each enabled band costs five products through the single shared 32x28
// multiplier fed by the one coefficient read port, then the product and accumulator
// registers and a round, clamp and history write-back state. Coefficient writes,
// history clears and ignored words leave the block idle. Coefficient and history
// stores come out of reset reading as zero through per-entry and per-row valid bits,
// so there is no clearing pass. Writing band_enable clears the history of every
// disabled band. The configuration port is always ready and may only be written
// while the block is idle.
`timescale 1ns / 1ps
module biquad_cascade_equaliser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bqeq_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bqeq_pkg::t_out_word          o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bqeq_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [bqeq_pkg::CFG_DW-1:0]  i_cfg_data
);
    import bqeq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,
        S_TAP,
        S_DRAIN,
        S_FIN,
        S_GAIN,
        S_GWAIT,
        S_GFIN
    } t_state;

    t_state                  r_state, n_state;
    logic [BAND_W-1:0]       r_band, n_band;
    logic [TAP_W-1:0]        r_tap, n_tap;
    logic                    r_drain, n_drain;
    logic                    r_p1_valid, n_p1_valid;
    logic [TAP_W-1:0]        r_p1_tap, n_p1_tap;
    logic [CH_W-1:0]         r_ch, n_ch;
    logic signed [SMP_W-1:0] r_x, n_x;
    logic                    r_sat, n_sat;
    logic [EN_W-1:0]         r_band_enable, n_band_enable;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic [C_DEPTH-1:0]      r_coef_valid, n_coef_valid;
    logic [H_DEPTH-1:0]      r_hist_valid, n_hist_valid;
    logic                    r_cv_q, n_cv_q;
    logic                    r_hv_q, n_hv_q;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    logic                    in_accept;
    logic                    cfg_accept;
    logic                    last_band;
    logic                    c_we;
    logic [C_AW-1:0]         c_waddr;
    logic                    c_re;
    logic [C_AW-1:0]         c_raddr;
    logic [COEF_W-1:0]       c_rdata;
    logic                    h_re;
    logic                    h_we;
    logic [H_AW-1:0]         h_addr;
    logic [HROW_W-1:0]       h_rdata;
    t_hist_row               h_wrow;
    t_hist_row               hist_eff;
    logic signed [COEF_W-1:0] coef_eff;
    t_mac_ctl                mac_ctl;
    logic signed [COEF_W-1:0] mac_a;
    logic signed [SMP_W-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    t_rnd                    band_rnd;
    t_rnd                    gain_rnd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign last_band   = (r_band == BAND_W'(BANDS - 1));

    assign c_we    = in_accept && (i_in_word.action == ACT_COEFF)
                     && (i_in_word.coeff_band < BANDS) && (i_in_word.coeff_slot < TAPS);
    assign c_waddr = coef_addr(i_in_word.coeff_band, i_in_word.coeff_slot);
    assign c_re    = (r_state == S_TAP);
    assign c_raddr = coef_addr(r_band, r_tap);
    assign h_re    = (r_state == S_TAP) && (r_tap == SLOT_B0);
    assign h_we    = (r_state == S_FIN);
    assign h_addr  = hist_addr(r_band, r_ch);

    assign coef_eff = r_cv_q ? $signed(c_rdata) : '0;
    assign hist_eff = r_hv_q ? t_hist_row'(h_rdata) : '0;
    assign band_rnd = round_band(mac_acc);
    assign gain_rnd = round_gain(mac_acc);

    assign h_wrow = '{x1: r_x, x2: hist_eff.x1, y1: band_rnd.val, y2: hist_eff.y1};

    bqeq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (C_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_in_word.coeff_value),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    bqeq_ram #(
        .WIDTH (HROW_W),
        .DEPTH (H_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_addr),
        .i_wdata (h_wrow),
        .i_re    (h_re),
        .i_raddr (h_addr),
        .o_rdata (h_rdata)
    );

    always_comb begin
        mac_ctl = '0;
        if (r_state == S_GAIN) begin
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.acc_clr = 1'b1;
            mac_a = $signed({{(COEF_W - GAIN_W){1'b0}}, r_gain});
            mac_b = r_x;
        end else begin
            mac_ctl.mul_en  = r_p1_valid;
            mac_ctl.sub     = (r_p1_tap == SLOT_A1) || (r_p1_tap == SLOT_A2);
            mac_ctl.acc_clr = (r_state == S_BAND) && r_band_enable[r_band];
            mac_a = coef_eff;
            unique case (r_p1_tap)
                SLOT_B0: mac_b = r_x;
                SLOT_B1: mac_b = hist_eff.x1;
                SLOT_B2: mac_b = hist_eff.x2;
                SLOT_A1: mac_b = hist_eff.y1;
                SLOT_A2: mac_b = hist_eff.y2;
                default: mac_b = '0;
            endcase
        end
    end

    bqeq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    always_comb begin
        n_state       = r_state;
        n_band        = r_band;
        n_tap         = r_tap;
        n_drain       = r_drain;
        n_p1_valid    = 1'b0;
        n_p1_tap      = r_p1_tap;
        n_ch          = r_ch;
        n_x           = r_x;
        n_sat         = r_sat;
        n_band_enable = r_band_enable;
        n_gain        = r_gain;
        n_coef_valid  = r_coef_valid;
        n_hist_valid  = r_hist_valid;
        n_cv_q        = r_cv_q;
        n_hv_q        = r_hv_q;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;

        if (c_we) begin
            n_coef_valid[c_waddr] = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_word.action)
                        ACT_SAMPLE: begin
                            if (i_in_word.channel < CHANNELS) begin
                                n_ch    = i_in_word.channel;
                                n_x     = i_in_word.sample_in;
                                n_sat   = 1'b0;
                                n_band  = '0;
                                n_state = S_BAND;
                            end
                        end
                        ACT_CLEAR: n_hist_valid = '0;
                        default: ;
                    endcase
                end
            end
            S_BAND: begin
                if (r_band_enable[r_band]) begin
                    n_tap   = SLOT_B0;
                    n_state = S_TAP;
                end else if (last_band) begin
                    n_state = S_GAIN;
                end else begin
                    n_band = r_band + 1'b1;
                end
            end
            S_TAP: begin
                n_p1_valid = 1'b1;
                n_p1_tap   = r_tap;
                n_cv_q     = r_coef_valid[c_raddr];
                if (r_tap == SLOT_B0) begin
                    n_hv_q = r_hist_valid[h_addr];
                end
                if (r_tap == SLOT_A2) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_x = band_rnd.val;
                n_sat = r_sat || band_rnd.sat;
                n_hist_valid[h_addr] = 1'b1;
                if (last_band) begin
                    n_state = S_GAIN;
                end else begin
                    n_band  = r_band + 1'b1;
                    n_state = S_BAND;
                end
            end
            S_GAIN: n_state = S_GWAIT;
            S_GWAIT: n_state = S_GFIN;
            S_GFIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.sample_out  = gain_rnd.val;
                    n_out.channel_out = r_ch;
                    n_out.saturated   = r_sat || gain_rnd.sat;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (cfg_accept) begin
            if (i_cfg_index == REG_BAND_ENABLE) begin
                n_band_enable = i_cfg_data[EN_W-1:0];
                for (int b = 0; b < BANDS; b++) begin
                    if (!n_band_enable[b]) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            n_hist_valid[hist_addr(BAND_W'(b), CH_W'(c))] = 1'b0;
                        end
                    end
                end
            end else if (i_cfg_index == REG_OUTPUT_GAIN) begin
                n_gain = i_cfg_data[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_p1_valid    <= 1'b0;
            r_band_enable <= '0;
            r_gain        <= GAIN_RESET;
            r_coef_valid  <= '0;
            r_hist_valid  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_band        <= n_band;
            r_tap         <= n_tap;
            r_drain       <= n_drain;
            r_p1_valid    <= n_p1_valid;
            r_p1_tap      <= n_p1_tap;
            r_ch          <= n_ch;
            r_x           <= n_x;
            r_sat         <= n_sat;
            r_band_enable <= n_band_enable;
            r_gain        <= n_gain;
            r_coef_valid  <= n_coef_valid;
            r_hist_valid  <= n_hist_valid;
            r_cv_q        <= n_cv_q;
            r_hv_q        <= n_hv_q;
            r_out_valid   <= n_out_valid;
            r_out         <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: hdl/bqeq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bqeq_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input bqeq_pkg::t_in_word   i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input bqeq_pkg::t_out_word  o_out_word
);
    import bqeq_pkg::*;

    logic in_take;
    logic in_sample;
    logic out_stall;

    assign in_take   = i_in_valid && o_in_ready;
    assign in_sample = (i_in_word.action == ACT_SAMPLE);
    assign out_stall = o_out_valid && !i_out_ready;

    // a sample word keeps the block busy
    `BQ_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, in_take && in_sample, !o_in_ready)

    // every other word leaves the block ready again in the next cycle
    `BQ_ASSERT_NEXT(a_other_fast, i_clk, i_rst_n, in_take && !in_sample, o_in_ready)

    // a new result only appears at the end of sample work
    `BQ_ASSERT_IMPL(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready))

    // stalled result holds
    `BQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_word))

endmodule

bind biquad_cascade_equaliser bqeq_checker u_bqeq_checker (.*);

FILE: dv/biquad_cascade_equaliser_checker.sv
`timescale 1ns / 1ps
module biquad_cascade_equaliser_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  bqeq_pkg::t_in_word           i_in_word,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  bqeq_pkg::t_out_word          i_out_word,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [bqeq_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [bqeq_pkg::CFG_DW-1:0]  i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);
    import bqeq_pkg::*;

    localparam longint SMP_HI = 134217727;
    localparam longint SMP_LO = -134217728;

    logic [EN_W-1:0]          band_en;
    logic [GAIN_W-1:0]        gain;
    logic signed [COEF_W-1:0] coefs [BANDS][TAPS];
    t_hist_row                hist  [BANDS][CHANNELS];
    t_out_word                results_due [$];
    t_out_word                want;

    // round half up at bit sh, then clamp to the sample range
    function automatic longint round_sat(input longint v, input int sh, inout logic sat);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > SMP_HI) begin
            sat = 1'b1;
            r   = SMP_HI;
        end else if (r < SMP_LO) begin
            sat = 1'b1;
            r   = SMP_LO;
        end
        return r;
    endfunction

    // zero the history of every band whose bit in keep is low
    function automatic void clear_hist(input logic [EN_W-1:0] keep);
        for (int b = 0; b < BANDS; b++) begin
            if (!keep[b]) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    hist[b][c] = '0;
                end
            end
        end
    endfunction

    function automatic t_out_word run_cascade(input t_in_word w);
        t_out_word r;
        t_hist_row h;
        logic      sat;
        longint    x;
        longint    y;
        longint    acc;
        sat = 1'b0;
        x   = longint'(w.sample_in);
        for (int b = 0; b < BANDS; b++) begin
            if (band_en[b]) begin
                h   = hist[b][w.channel];
                acc = longint'(coefs[b][SLOT_B0]) * x
                    + longint'(coefs[b][SLOT_B1]) * longint'(h.x1)
                    + longint'(coefs[b][SLOT_B2]) * longint'(h.x2)
                    - longint'(coefs[b][SLOT_A1]) * longint'(h.y1)
                    - longint'(coefs[b][SLOT_A2]) * longint'(h.y2);
                y    = round_sat(acc, 30, sat);
                h.x2 = h.x1;
                h.x1 = x[SMP_W-1:0];
                h.y2 = h.y1;
                h.y1 = y[SMP_W-1:0];
                hist[b][w.channel] = h;
                x = y;
            end
        end
        x = round_sat(x * longint'(gain), 20, sat);
        r.sample_out  = x[SMP_W-1:0];
        r.channel_out = w.channel;
        r.saturated   = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            band_en = '0;
            gain    = GAIN_RESET;
            for (int b = 0; b < BANDS; b++) begin
                for (int t = 0; t < TAPS; t++) begin
                    coefs[b][t] = '0;
                end
            end
            clear_hist('0);
            results_due.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BAND_ENABLE) begin
                    band_en = i_cfg_data[EN_W-1:0];
                    clear_hist(band_en);
                end else if (i_cfg_index == REG_OUTPUT_GAIN) begin
                    gain = i_cfg_data[GAIN_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_word.action)
                    ACT_SAMPLE: begin
                        results_due.push_back(run_cascade(i_in_word));
                    end
                    ACT_COEFF: begin
                        if (i_in_word.coeff_slot < TAPS) begin
                            coefs[i_in_word.coeff_band][i_in_word.coeff_slot] =
                                i_in_word.coeff_value;
                        end
                    end
                    ACT_CLEAR: begin
                        clear_hist('0);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: unexpected output word out=%0d ch=%0d sat=%0b", $time,
                                 i_out_word.sample_out, i_out_word.channel_out,
                                 i_out_word.saturated);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (want.sample_out !== i_out_word.sample_out ||
                        want.channel_out !== i_out_word.channel_out ||
                        want.saturated !== i_out_word.saturated) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $write("%0t: output mismatch, expected out=%0d ch=%0d sat=%0b,",
                                   $time, want.sample_out, want.channel_out,
                                   want.saturated);
                            $display(" got out=%0d ch=%0d sat=%0b",
                                     i_out_word.sample_out, i_out_word.channel_out,
                                     i_out_word.saturated);
                        end
                    end
                end
            end
            o_pending = results_due.size();
        end
    end

endmodule

FILE: dv/tb_biquad_cascade_equaliser.sv
`timescale 1ns / 1ps
module tb_biquad_cascade_equaliser;
    import bqeq_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 75;

    localparam logic [1:0]        ACT_UNUSED = 2'd3;
    localparam logic [CFG_IW-1:0] REG_UNUSED = 4'hF;

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W - 1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W - 1){1'b0}}};
    localparam logic [COEF_W-1:0]       COEF_ONE = 32'h4000_0000;
    localparam logic [COEF_W-1:0]       COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]       COEF_MIN = 32'h8000_0000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_word          in_word   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_word         out_word;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;
    int                errors;
    int                pending;
    int                send_calm = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    biquad_cascade_equaliser i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    biquad_cascade_equaliser_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function automatic t_in_word noise_word();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word sample_word(input logic ch, input logic signed [SMP_W-1:0] v);
        t_in_word w;
        w           = noise_word();
        w.action    = ACT_SAMPLE;
        w.channel   = ch;
        w.sample_in = v;
        return w;
    endfunction

    function automatic t_in_word coef_word(input logic [BAND_W-1:0] band,
                                           input logic [TAP_W-1:0] slot,
                                           input logic [COEF_W-1:0] v);
        t_in_word w;
        w             = noise_word();
        w.action      = ACT_COEFF;
        w.coeff_band  = band;
        w.coeff_slot  = slot;
        w.coeff_value = v;
        return w;
    endfunction

    function automatic t_in_word marked_word(input logic [1:0] act);
        t_in_word w;
        w        = noise_word();
        w.action = act;
        return w;
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        logic [31:0] r;
        int          v;
        r = $urandom;
        v = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        case ($urandom_range(0, 9))
            0, 1: return r[SMP_W-1:0];
            2: return r[0] ? SMP_MAX : SMP_MIN;
            default: return v[SMP_W-1:0];
        endcase
    endfunction

    task automatic push_word(input t_in_word w);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 15) == 0) begin
                send_calm = $urandom_range(10, 40);
            end
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    // registers only change once the block has drained
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stable biquad unless wild, then any 32-bit values
    task automatic load_band(input int b, input bit wild);
        longint            a1;
        longint            a2;
        longint            lim;
        longint            b0;
        longint            b1;
        longint            b2;
        logic [BAND_W-1:0] band;
        band = b[BAND_W-1:0];
        a2   = longint'($urandom_range(0, 1717986918)) - 858993459;
        lim  = ((longint'(1) << 30) + a2) * 9 / 10;
        a1   = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        b0   = longint'($urandom_range(0, 32'h7FFF_FFFF)) - (longint'(1) << 30);
        b1   = longint'($urandom_range(0, 32'h7FFF_FFFF)) - (longint'(1) << 30);
        b2   = longint'($urandom_range(0, 32'h7FFF_FFFF)) - (longint'(1) << 30);
        push_word(coef_word(band, SLOT_B0, wild ? $urandom : b0[COEF_W-1:0]));
        push_word(coef_word(band, SLOT_B1, wild ? $urandom : b1[COEF_W-1:0]));
        push_word(coef_word(band, SLOT_B2, wild ? $urandom : b2[COEF_W-1:0]));
        push_word(coef_word(band, SLOT_A1, wild ? $urandom : a1[COEF_W-1:0]));
        push_word(coef_word(band, SLOT_A2, wild ? $urandom : a2[COEF_W-1:0]));
    endtask

    task automatic random_word();
        int       pick;
        t_in_word w;
        pick = $urandom_range(0, 99);
        w    = noise_word();
        if (pick < 78) begin
            w.action    = ACT_SAMPLE;
            w.sample_in = rand_sample();
        end else if (pick < 86) begin
            w.action      = ACT_COEFF;
            w.coeff_slot  = 3'($urandom_range(0, TAPS - 1));
            w.coeff_value = 32'($urandom_range(0, 32'h7FFF_FFFF)) - COEF_ONE;
        end else if (pick < 89) begin
            w.action = ACT_CLEAR;
        end else if (pick < 94) begin
            w.action     = ACT_COEFF;
            w.coeff_slot = 3'($urandom_range(TAPS, 7));
        end else if (pick < 96) begin
            w.action = ACT_UNUSED;
        end
        push_word(w);
    endtask

    // output side, with two long hold-offs to back the block up
    initial begin
        int stall;
        int taken;
        int calm;
        taken = 0;
        calm  = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (taken == 60 || taken == 400) begin
                stall = 600;
            end else if (calm > 0) begin
                stall = 0;
                calm--;
            end else begin
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0) begin
                    calm = $urandom_range(10, 40);
                end
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [EN_W-1:0]   en;
        logic [GAIN_W-1:0] gain;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all bands off after reset: straight through at unity gain
        push_word(sample_word(1'b0, SMP_MAX));
        push_word(sample_word(1'b1, SMP_MIN));
        push_word(sample_word(1'b0, '0));
        push_word(coef_word(3'd0, SLOT_B0, COEF_ONE));
        push_word(coef_word(3'd0, SLOT_B1, '0));
        push_word(coef_word(3'd0, SLOT_B2, '0));
        push_word(coef_word(3'd0, SLOT_A1, '0));
        push_word(coef_word(3'd0, SLOT_A2, '0));
        push_word(coef_word(3'd2, SLOT_B0, COEF_MIN));
        push_word(coef_word(3'd2, SLOT_B1, COEF_MAX));
        push_word(coef_word(3'd0, 3'd5, COEF_MAX));
        push_word(coef_word(3'd2, 3'd7, COEF_MAX));
        push_word(marked_word(ACT_UNUSED));
        push_word(marked_word(ACT_CLEAR));

        write_reg(REG_BAND_ENABLE, 24'h000001);
        write_reg(REG_OUTPUT_GAIN, 24'hFF_FFFF);
        push_word(sample_word(1'b0, SMP_MAX));
        push_word(sample_word(1'b1, 28'sh0123456));

        // band never loaded gives silence
        write_reg(REG_BAND_ENABLE, 24'hFF0002);
        push_word(sample_word(1'b0, 28'sh0654321));

        write_reg(REG_BAND_ENABLE, 24'h000004);
        push_word(sample_word(1'b0, SMP_MIN));
        push_word(sample_word(1'b0, SMP_MAX));

        write_reg(REG_OUTPUT_GAIN, '0);
        push_word(sample_word(1'b1, SMP_MAX));
        write_reg(REG_UNUSED, '1);
        write_reg(REG_OUTPUT_GAIN, GAIN_RESET);
        push_word(sample_word(1'b1, 28'sh0800000));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    en   = 8'hFF;
                    gain = GAIN_RESET;
                end
                1: begin
                    en   = 8'($urandom);
                    gain = '1;
                end
                2: begin
                    en   = '0;
                    gain = 24'($urandom_range(24'h080000, 24'h200000));
                end
                3: begin
                    en   = 8'($urandom);
                    gain = '0;
                end
                4: begin
                    en   = 8'hFF;
                    gain = 24'($urandom);
                end
                default: begin
                    en   = 8'($urandom);
                    gain = 24'($urandom_range(24'h080000, 24'h200000));
                end
            endcase
            write_reg(REG_BAND_ENABLE, {16'($urandom), en});
            write_reg(REG_OUTPUT_GAIN, gain);
            for (int b = 0; b < BANDS; b++) begin
                if (ph == 0 || $urandom_range(0, 2) != 0) begin
                    load_band(b, ph == 5);
                end
            end
            repeat (PHASE_WORDS) random_word();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
